// ===== design/rtih_pkg.sv =====
// Shared types, constants and state encodings of the route table hash block.
`default_nettype none

package rtih_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam int HOP_W    = 6;
  localparam int NODE_W   = 6;
  localparam int REG_W    = 7;
  localparam int CFG_IDX_W = 4;
  localparam int COUNT_OUT_W = 13;

  localparam logic [REG_W-1:0] REG_RESET = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_COUNT   = 4'd1;

  // Command codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SRC  = 2'd1;
  localparam logic [1:0] STATUS_BAD_DST  = 2'd2;
  localparam logic [1:0] STATUS_BAD_HOP  = 2'd3;

  // Hash constants.
  localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_K1     = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_K2     = 64'h94d049bb133111eb;
  localparam logic [63:0] SALT_DST   = 64'h00000100000001b3;
  localparam logic [63:0] SALT_HOP   = 64'h517cc1b727220a95;

  typedef struct packed {
    logic              command;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] destination_node;
    logic [HOP_W-1:0]  next_hop;
    logic              delete_route;
  } item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   was_present;
    logic [HOP_W-1:0]       old_next_hop;
    logic                   changed;
    logic [COUNT_OUT_W-1:0] route_count;
    logic [63:0]            state_hash;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic [HOP_W-1:0] hop;
  } entry_t;

  typedef enum logic [1:0] {
    MX_IDLE,
    MX_LL,
    MX_HL,
    MX_LH
  } mx_state_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MIX_SRC,
    ST_MIX_DST,
    ST_MIX_OLD_HOP,
    ST_MIX_OLD_SUM,
    ST_MIX_NEW_HOP,
    ST_MIX_NEW_SUM,
    ST_DONE
  } rt_state_e;

endpackage

`default_nettype wire

// ===== design/rtih_mix.sv =====
// Iterative splitmix64 finalizer built around one shared 32x32 multiplier.
`default_nettype none

module rtih_mix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] x_i,
  output logic             done_o,
  output logic [63:0]      result_o
);

  rtih_pkg::mx_state_e state_q, state_d;
  logic        round_q, round_d;
  logic        done_q, done_d;
  logic [63:0] z_q, z_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] res_q, res_d;

  logic [63:0] k;
  logic [31:0] a_part, b_part;
  logic [63:0] prod;
  logic [63:0] sum;
  logic [63:0] pre;

  assign k    = round_q ? rtih_pkg::MIX_K2 : rtih_pkg::MIX_K1;
  assign prod = 64'(a_part) * 64'(b_part);
  assign sum  = acc_q + {prod[31:0], 32'b0};
  assign pre  = x_i + rtih_pkg::MIX_GOLDEN;

  // A 64-bit product modulo 2^64 is built from three 32-bit partial products.
  always_comb begin
    state_d = state_q;
    round_d = round_q;
    done_d  = 1'b0;
    z_d     = z_q;
    acc_d   = acc_q;
    res_d   = res_q;
    a_part  = z_q[31:0];
    b_part  = k[31:0];
    unique case (state_q)
      rtih_pkg::MX_IDLE: begin
        if (start_i) begin
          z_d     = pre ^ (pre >> 30);
          round_d = 1'b0;
          state_d = rtih_pkg::MX_LL;
        end
      end
      rtih_pkg::MX_LL: begin
        acc_d   = prod;
        state_d = rtih_pkg::MX_HL;
      end
      rtih_pkg::MX_HL: begin
        a_part  = z_q[63:32];
        acc_d   = sum;
        state_d = rtih_pkg::MX_LH;
      end
      rtih_pkg::MX_LH: begin
        b_part = k[63:32];
        if (!round_q) begin
          z_d     = sum ^ (sum >> 27);
          round_d = 1'b1;
          state_d = rtih_pkg::MX_LL;
        end else begin
          res_d   = sum ^ (sum >> 31);
          done_d  = 1'b1;
          state_d = rtih_pkg::MX_IDLE;
        end
      end
      default: state_d = rtih_pkg::MX_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtih_pkg::MX_IDLE;
      round_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    acc_q <= acc_d;
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== design/rtih_table.sv =====
// Route entry memory with a clearing sweep after reset.
`default_nettype none

module rtih_table #(
  parameter int MAX_NODES = rtih_pkg::MAX_NODES_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [$clog2(MAX_NODES*MAX_NODES)-1:0] raddr_i,
  input  wire logic                                   we_i,
  input  wire logic [$clog2(MAX_NODES*MAX_NODES)-1:0] waddr_i,
  input  wire rtih_pkg::entry_t                       wdata_i,
  output rtih_pkg::entry_t                            rdata_o,
  output logic                                        clearing_o
);

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);

  rtih_pkg::entry_t mem [DEPTH];
  rtih_pkg::entry_t rdata_q;

  logic          clr_active_q, clr_active_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_addr_d   = clr_addr_q;
    if (clr_active_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_addr_q   <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_active_q;

endmodule

`default_nettype wire

// ===== design/route_table_incremental_hash_top.sv =====
// Top level of the route table with incremental order-independent hash.
//
// Usage: an item (get or set of one source/destination route) is transferred
// at a clock edge with start high and busy low. busy stays high while the
// item is processed; one result appears on result_o for exactly one cycle,
// marked by result_valid_o. The receiver cannot stall, so the result must be
// taken in that cycle. Registers source_count and destination_count are
// written over the cfg channel (cfg_ready_o is always high).
// Flow: gets, rejected items and sets that change nothing go from the read
// state straight to the done state; busy drops in the strobe cycle, so the
// next item can transfer in that cycle. A set that changes an entry runs the
// splitmix64 finalizer on the shared 32x32 multiplier, one finalizer after
// another: an insert or delete needs 4 finalizers, a replacement 6 finalizers.
// Reset: the count and hash clear and both registers return to 64 at once,
// then the entry memory is swept one entry a cycle over all MAX_NODES*MAX_NODES
// entries (4096 at the default); busy stays high during the sweep, config
// writes still transfer.
`default_nettype none

module route_table_incremental_hash_top #(
  parameter int MAX_NODES = rtih_pkg::MAX_NODES_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire rtih_pkg::item_t                   item_i,
  output logic                                   result_valid_o,
  output rtih_pkg::result_t                      result_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rtih_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rtih_pkg::REG_W-1:0]        cfg_data_i
);

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  rtih_pkg::rt_state_e state_q, state_d;

  rtih_pkg::item_t   item_q, item_d;
  logic [1:0]        status_q, status_d;
  logic              was_q, was_d;
  logic [rtih_pkg::HOP_W-1:0] old_q, old_d;
  logic              changed_q, changed_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [63:0]       base_q, base_d;
  logic [63:0]       hash_q, hash_d;
  logic [CW-1:0]     count_q, count_d;
  logic [rtih_pkg::REG_W-1:0] src_cnt_q, src_cnt_d;
  logic [rtih_pkg::REG_W-1:0] dst_cnt_q, dst_cnt_d;
  logic              result_valid_q, result_valid_d;
  rtih_pkg::result_t result_q, result_d;

  logic              accept;
  logic              clearing;
  logic [AW-1:0]     in_addr;
  logic [1:0]        in_status;
  logic              src_bad, dst_bad, hop_bad;
  rtih_pkg::entry_t  rd_entry;
  logic              tbl_we;
  rtih_pkg::entry_t  tbl_wdata;
  logic              mix_start;
  logic [63:0]       mix_x;
  logic              mix_done;
  logic [63:0]       mix_result;
  logic              same;

  assign accept      = start && !busy;
  assign busy        = (state_q != rtih_pkg::ST_IDLE) || clearing;
  assign cfg_ready_o = 1'b1;

  // Bound is the register capped at MAX_NODES, so test against both.
  assign src_bad = (32'(item_i.source_node) >= 32'(src_cnt_q)) ||
                   (32'(item_i.source_node) >= MAX_NODES);
  assign dst_bad = (32'(item_i.destination_node) >= 32'(dst_cnt_q)) ||
                   (32'(item_i.destination_node) >= MAX_NODES);
  assign hop_bad = (item_i.command == rtih_pkg::CMD_SET) && !item_i.delete_route &&
                   ((32'(item_i.next_hop) >= 32'(dst_cnt_q)) ||
                    (32'(item_i.next_hop) >= MAX_NODES));

  always_comb begin
    if (src_bad) begin
      in_status = rtih_pkg::STATUS_BAD_SRC;
    end else if (dst_bad) begin
      in_status = rtih_pkg::STATUS_BAD_DST;
    end else if (hop_bad) begin
      in_status = rtih_pkg::STATUS_BAD_HOP;
    end else begin
      in_status = rtih_pkg::STATUS_OK;
    end
  end

  assign in_addr = AW'(32'(item_i.source_node) * MAX_NODES + 32'(item_i.destination_node));

  assign same = item_q.delete_route ? !rd_entry.valid
                                    : (rd_entry.valid && (rd_entry.hop == item_q.next_hop));

  rtih_table #(
    .MAX_NODES (MAX_NODES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .raddr_i    (in_addr),
    .we_i       (tbl_we),
    .waddr_i    (addr_q),
    .wdata_i    (tbl_wdata),
    .rdata_o    (rd_entry),
    .clearing_o (clearing)
  );

  rtih_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mix_start),
    .x_i      (mix_x),
    .done_o   (mix_done),
    .result_o (mix_result)
  );

  // Configuration registers.
  always_comb begin
    src_cnt_d = src_cnt_q;
    dst_cnt_d = dst_cnt_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rtih_pkg::CFG_SOURCE_COUNT: src_cnt_d = cfg_data_i;
        rtih_pkg::CFG_DEST_COUNT:   dst_cnt_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: read the entry, then run the finalizer jobs a changing set needs.
  always_comb begin
    state_d        = state_q;
    item_d         = item_q;
    status_d       = status_q;
    was_d          = was_q;
    old_d          = old_q;
    changed_d      = changed_q;
    addr_d         = addr_q;
    base_d         = base_q;
    hash_d         = hash_q;
    count_d        = count_q;
    result_valid_d = 1'b0;
    result_d       = result_q;
    mix_start      = 1'b0;
    mix_x          = 64'(item_q.source_node);
    tbl_we         = 1'b0;
    tbl_wdata.valid = !item_q.delete_route;
    tbl_wdata.hop   = item_q.delete_route ? '0 : item_q.next_hop;
    unique case (state_q)
      rtih_pkg::ST_IDLE: begin
        if (accept) begin
          item_d    = item_i;
          status_d  = in_status;
          addr_d    = in_addr;
          changed_d = 1'b0;
          state_d   = rtih_pkg::ST_READ;
        end
      end
      rtih_pkg::ST_READ: begin
        if (status_q != rtih_pkg::STATUS_OK) begin
          was_d   = 1'b0;
          old_d   = '0;
          state_d = rtih_pkg::ST_DONE;
        end else begin
          was_d = rd_entry.valid;
          old_d = rd_entry.valid ? rd_entry.hop : '0;
          if ((item_q.command == rtih_pkg::CMD_GET) || same) begin
            state_d = rtih_pkg::ST_DONE;
          end else begin
            changed_d = 1'b1;
            mix_start = 1'b1;
            mix_x     = 64'(item_q.source_node);
            state_d   = rtih_pkg::ST_MIX_SRC;
          end
        end
      end
      rtih_pkg::ST_MIX_SRC: begin
        if (mix_done) begin
          base_d    = mix_result;
          mix_start = 1'b1;
          mix_x     = 64'(item_q.destination_node) + rtih_pkg::SALT_DST;
          state_d   = rtih_pkg::ST_MIX_DST;
        end
      end
      rtih_pkg::ST_MIX_DST: begin
        if (mix_done) begin
          base_d    = base_q ^ mix_result;
          mix_start = 1'b1;
          if (was_q) begin
            mix_x   = 64'(old_q) + rtih_pkg::SALT_HOP;
            state_d = rtih_pkg::ST_MIX_OLD_HOP;
          end else begin
            mix_x   = 64'(item_q.next_hop) + rtih_pkg::SALT_HOP;
            state_d = rtih_pkg::ST_MIX_NEW_HOP;
          end
        end
      end
      rtih_pkg::ST_MIX_OLD_HOP: begin
        if (mix_done) begin
          mix_start = 1'b1;
          mix_x     = base_q ^ mix_result;
          state_d   = rtih_pkg::ST_MIX_OLD_SUM;
        end
      end
      rtih_pkg::ST_MIX_OLD_SUM: begin
        if (mix_done) begin
          hash_d  = hash_q ^ mix_result;
          count_d = count_q - CW'(1);
          if (item_q.delete_route) begin
            state_d = rtih_pkg::ST_DONE;
          end else begin
            mix_start = 1'b1;
            mix_x     = 64'(item_q.next_hop) + rtih_pkg::SALT_HOP;
            state_d   = rtih_pkg::ST_MIX_NEW_HOP;
          end
        end
      end
      rtih_pkg::ST_MIX_NEW_HOP: begin
        if (mix_done) begin
          mix_start = 1'b1;
          mix_x     = base_q ^ mix_result;
          state_d   = rtih_pkg::ST_MIX_NEW_SUM;
        end
      end
      rtih_pkg::ST_MIX_NEW_SUM: begin
        if (mix_done) begin
          hash_d  = hash_q ^ mix_result;
          count_d = count_q + CW'(1);
          state_d = rtih_pkg::ST_DONE;
        end
      end
      rtih_pkg::ST_DONE: begin
        tbl_we                = changed_q;
        result_valid_d        = 1'b1;
        result_d.status       = status_q;
        result_d.was_present  = was_q;
        result_d.old_next_hop = old_q;
        result_d.changed      = changed_q;
        result_d.route_count  = rtih_pkg::COUNT_OUT_W'(count_q);
        result_d.state_hash   = hash_q;
        state_d               = rtih_pkg::ST_IDLE;
      end
      default: state_d = rtih_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rtih_pkg::ST_IDLE;
      hash_q         <= '0;
      count_q        <= '0;
      src_cnt_q      <= rtih_pkg::REG_RESET;
      dst_cnt_q      <= rtih_pkg::REG_RESET;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      hash_q         <= hash_d;
      count_q        <= count_d;
      src_cnt_q      <= src_cnt_d;
      dst_cnt_q      <= dst_cnt_d;
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    status_q  <= status_d;
    was_q     <= was_d;
    old_q     <= old_d;
    changed_q <= changed_d;
    addr_q    <= addr_d;
    base_q    <= base_d;
    result_q  <= result_d;
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

`ifndef SYNTHESIS
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item transfer");

  a_reject_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.status != rtih_pkg::STATUS_OK)) |->
      (!result_o.was_present && !result_o.changed && (result_o.old_next_hop == '0)))
    else $error("rejected item reported route data");

  a_mix_idle_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mix_start |-> ((state_q == rtih_pkg::ST_READ) || mix_done))
    else $error("finalizer started while still running");
`endif

endmodule

`default_nettype wire
